// ===== design/assert_macros.svh =====
// Assertion macros for the design files; strip_tangent_bitangent.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold in the same cycle.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication that must hold in the next cycle.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/stb_pkg.sv =====
// Types and constants for the strip tangent and bitangent block.
package stb_pkg;

  localparam int TEX_FRAC_BITS = 16;
  localparam int DIV_STEPS     = 52 + TEX_FRAC_BITS;

  typedef struct packed {
    logic               segment_start;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [16:0]        tex_s;
    logic [16:0]        tex_t;
  } vtx_t;

  typedef struct packed {
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic signed [31:0] bitangent_x;
    logic signed [31:0] bitangent_y;
    logic signed [31:0] bitangent_z;
    logic               degenerate;
    logic               saturated;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_M0,
    S_M1,
    S_M2,
    S_DIV,
    S_DONE
  } state_t;

endpackage

// ===== design/strip_tangent_bitangent.sv =====
// Top level: strip window, shared multiplier and bit-serial divider.
//
//   channel | direction | handshake             | payload
//   vtx     | in        | vtx_valid, vtx_stall  | stb_pkg::vtx_t
//   res     | out       | res_valid, res_stall  | stb_pkg::res_t
//
// A vertex that only fills the window is taken while idle and gives no result.
// A vertex on a full window first forms the determinant on the shared multiplier in
// S_M0, S_M1 and S_M2, then for each of six components runs the same multiplier states
// and then the restoring divider in S_DIV. A zero determinant skips the components
// and finishes right after the determinant.
// Reset empties the window and the result register.
// A stalled result waits in its register; the next vertex is taken meanwhile.
`include "assert_macros.svh"

module strip_tangent_bitangent (
  input  logic           clk,
  input  logic           rst,
  input  logic           vtx_valid,
  output logic           vtx_stall,
  input  stb_pkg::vtx_t  vtx,
  output logic           res_valid,
  input  logic           res_stall,
  output stb_pkg::res_t  res
);

  stb_pkg::state_t state, state_next;

  // Window storage.
  logic signed [31:0] old_pos [3];
  logic signed [31:0] mid_pos [3];
  logic [16:0]        old_s, old_t, mid_s, mid_t;
  logic [1:0]         fill;

  // Operands latched at the start of a computation.
  logic signed [32:0] e1 [3];
  logic signed [32:0] e2 [3];
  logic signed [17:0] du1, dv1, du2, dv2;

  // Shared arithmetic.
  logic signed [50:0] prod;
  logic signed [51:0] acc;
  logic signed [37:0] det;
  logic [36:0]        dmag;
  logic               neg;
  logic [1:0]         comp;
  logic               is_bit;
  logic               det_phase;
  logic [67:0]        div_n;
  logic [37:0]        rem;
  logic [33:0]        quot;
  logic               ovf;
  logic [6:0]         cnt;
  logic               degen, sat;
  logic signed [31:0] tan_r [3];
  logic signed [31:0] bit_r [3];

  logic               vtx_acc, res_free, fill_lo;
  logic [1:0]         fill_eff;
  logic signed [32:0] in_pos [3];
  logic signed [17:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [51:0] diff;
  logic [37:0]        rem_sh, rem_nx;
  logic               ge;
  logic [33:0]        quot_nx;
  logic               big;
  logic [31:0]        div_res;
  logic               div_sat;
  logic [51:0]        n_abs;

  assign vtx_acc  = vtx_valid && !vtx_stall;
  assign vtx_stall = (state != stb_pkg::S_IDLE);
  assign res_free = !res_valid || !res_stall;
  assign fill_eff = vtx.segment_start ? 2'd0 : fill;
  assign fill_lo  = (fill_eff != 2'd2);
  assign in_pos[0] = 33'(vtx.pos_x);
  assign in_pos[1] = 33'(vtx.pos_y);
  assign in_pos[2] = 33'(vtx.pos_z);

  // Multiplier operand selection.
  always_comb begin
    if (det_phase) begin
      mul_a = (state == stb_pkg::S_M0) ? du1 : du2;
      mul_b = (state == stb_pkg::S_M0) ? 33'(dv2) : 33'(dv1);
    end else if (!is_bit) begin
      mul_a = (state == stb_pkg::S_M0) ? dv2 : dv1;
      mul_b = (state == stb_pkg::S_M0) ? e1[comp] : e2[comp];
    end else begin
      mul_a = (state == stb_pkg::S_M0) ? du1 : du2;
      mul_b = (state == stb_pkg::S_M0) ? e2[comp] : e1[comp];
    end
  end

  assign diff  = acc - 52'(prod);
  assign n_abs = diff[51] ? 52'(-diff) : diff;

  // One restoring division step.
  assign rem_sh  = {rem[36:0], div_n[67]};
  assign ge      = (rem_sh >= {1'b0, dmag});
  assign rem_nx  = ge ? (rem_sh - {1'b0, dmag}) : rem_sh;
  assign quot_nx = {quot[32:0], ge};

  // Saturation of the finished quotient.
  always_comb begin
    big = ovf || quot[33] || quot_nx[33] || quot_nx[32];
    div_sat = 1'b0;
    if (neg) begin
      if (big || (quot_nx[31] && (quot_nx[30:0] != 31'd0))) begin
        div_res = 32'h8000_0000;
        div_sat = 1'b1;
      end else begin
        div_res = 32'(-quot_nx[31:0]);
      end
    end else begin
      if (big || quot_nx[31]) begin
        div_res = 32'h7FFF_FFFF;
        div_sat = 1'b1;
      end else begin
        div_res = quot_nx[31:0];
      end
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      stb_pkg::S_IDLE: begin
        if (vtx_acc && !fill_lo) state_next = stb_pkg::S_M0;
      end
      stb_pkg::S_M0: state_next = stb_pkg::S_M1;
      stb_pkg::S_M1: state_next = stb_pkg::S_M2;
      stb_pkg::S_M2: begin
        if (det_phase && diff == 52'sd0) state_next = stb_pkg::S_DONE;
        else if (det_phase) state_next = stb_pkg::S_M0;
        else state_next = stb_pkg::S_DIV;
      end
      stb_pkg::S_DIV: begin
        if (cnt == 7'(stb_pkg::DIV_STEPS - 1)) begin
          if (is_bit && comp == 2'd2) state_next = stb_pkg::S_DONE;
          else state_next = stb_pkg::S_M0;
        end
      end
      stb_pkg::S_DONE: begin
        if (res_free) state_next = stb_pkg::S_IDLE;
      end
      default: state_next = stb_pkg::S_IDLE;
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= stb_pkg::S_IDLE;
      fill      <= 2'd0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (vtx_acc) fill <= fill_lo ? fill_eff + 2'd1 : 2'd2;
      if (state == stb_pkg::S_DONE && res_free) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (vtx_acc) begin
      if (fill_eff == 2'd0) begin
        old_pos[0] <= vtx.pos_x;
        old_pos[1] <= vtx.pos_y;
        old_pos[2] <= vtx.pos_z;
        old_s <= vtx.tex_s;
        old_t <= vtx.tex_t;
      end else if (fill_eff == 2'd1) begin
        mid_pos[0] <= vtx.pos_x;
        mid_pos[1] <= vtx.pos_y;
        mid_pos[2] <= vtx.pos_z;
        mid_s <= vtx.tex_s;
        mid_t <= vtx.tex_t;
      end else begin
        for (int i = 0; i < 3; i++) begin
          e1[i] <= 33'(mid_pos[i]) - 33'(old_pos[i]);
          e2[i] <= in_pos[i] - 33'(mid_pos[i]);
          old_pos[i] <= mid_pos[i];
        end
        mid_pos[0] <= vtx.pos_x;
        mid_pos[1] <= vtx.pos_y;
        mid_pos[2] <= vtx.pos_z;
        du1 <= $signed({1'b0, mid_s}) - $signed({1'b0, old_s});
        dv1 <= $signed({1'b0, mid_t}) - $signed({1'b0, old_t});
        du2 <= $signed({1'b0, vtx.tex_s}) - $signed({1'b0, mid_s});
        dv2 <= $signed({1'b0, vtx.tex_t}) - $signed({1'b0, mid_t});
        old_s <= mid_s;
        old_t <= mid_t;
        mid_s <= vtx.tex_s;
        mid_t <= vtx.tex_t;
        det_phase <= 1'b1;
        comp   <= 2'd0;
        is_bit <= 1'b0;
        sat    <= 1'b0;
        degen  <= 1'b0;
      end
    end

    // Multiply, then accumulate the difference of two products.
    if (state == stb_pkg::S_M0 || state == stb_pkg::S_M1) prod <= 51'(mul_a) * 51'(mul_b);
    if (state == stb_pkg::S_M1) acc <= 52'(prod);

    if (state == stb_pkg::S_M2) begin
      if (det_phase) begin
        det       <= diff[37:0];
        dmag      <= diff[51] ? 37'(-diff) : 37'(diff);
        det_phase <= 1'b0;
        if (diff == 52'sd0) begin
          degen <= 1'b1;
          for (int i = 0; i < 3; i++) begin
            tan_r[i] <= 32'sd0;
            bit_r[i] <= 32'sd0;
          end
        end
      end else begin
        neg   <= diff[51] ^ det[37];
        div_n <= {n_abs, 16'd0};
        rem   <= 38'd0;
        quot  <= 34'd0;
        ovf   <= 1'b0;
        cnt   <= 7'd0;
      end
    end

    // Divider steps; the last one writes the component.
    if (state == stb_pkg::S_DIV) begin
      div_n <= {div_n[66:0], 1'b0};
      rem   <= rem_nx;
      quot  <= quot_nx;
      ovf   <= ovf | quot[33];
      cnt   <= cnt + 7'd1;
      if (cnt == 7'(stb_pkg::DIV_STEPS - 1)) begin
        if (is_bit) bit_r[comp] <= div_res;
        else tan_r[comp] <= div_res;
        sat <= sat | div_sat;
        if (is_bit) begin
          is_bit <= 1'b0;
          comp   <= comp + 2'd1;
        end else begin
          is_bit <= 1'b1;
        end
      end
    end

    // Result register.
    if (state == stb_pkg::S_DONE && res_free) begin
      res.tangent_x   <= tan_r[0];
      res.tangent_y   <= tan_r[1];
      res.tangent_z   <= tan_r[2];
      res.bitangent_x <= bit_r[0];
      res.bitangent_y <= bit_r[1];
      res.bitangent_z <= bit_r[2];
      res.degenerate  <= degen;
      res.saturated   <= sat;
    end
  end

  // The window never claims more than two held vertices.
  `ASSERT_IMP(a_fill_range, clk, rst, 1'b1, fill != 2'd3)
  // A vertex that only fills the window leaves the block idle.
  `ASSERT_NXT(a_fill_idle, clk, rst, vtx_acc && fill_lo, state == stb_pkg::S_IDLE)
  // The divider count stays within its steps.
  `ASSERT_IMP(a_div_cnt, clk, rst, state == stb_pkg::S_DIV, cnt < 7'(stb_pkg::DIV_STEPS))
  // A degenerate result never reports clamping.
  `ASSERT_IMP(a_degen_sat, clk, rst, res_valid && res.degenerate, !res.saturated)

endmodule
